### rtl/hri_pkg.sv
// ----------------------------------------------------------------------------
// hri_pkg: shared constants and types for the radical inverse core
// Widths of index, fraction, digit registers and the cell-row depth.
// ----------------------------------------------------------------------------
`default_nettype none
package hri_pkg;
	localparam int INDEX_BITS    = 31;
	localparam int FRACTION_BITS = 32;
	localparam int RADIX_BITS    = 8;
	localparam int MAX_DIGITS    = INDEX_BITS;
	localparam int DCNT_BITS     = $clog2(MAX_DIGITS + 1);
	localparam int BCNT_BITS     = $clog2(FRACTION_BITS + 1);

	typedef logic [INDEX_BITS-1:0]    index_t;
	typedef logic [FRACTION_BITS-1:0] frac_t;
	typedef logic [RADIX_BITS-1:0]    digit_t;

	// control from the sequencer to the digit row
	typedef struct packed {
		logic load;   // clear the row
		logic push;   // shift a new digit in at the head
		logic pop;    // shift the row toward the head, the head digit leaves
	} row_ctl_t;
endpackage
`default_nettype wire

### rtl/hri_cell.sv
// ----------------------------------------------------------------------------
// hri_cell: one digit slot of the digit row
// Holds one digit; takes the neighbor's digit on push or pop.
// ----------------------------------------------------------------------------
`default_nettype none
module hri_cell (
	input  wire logic            clk,
	input  wire hri_pkg::row_ctl_t ctl,
	input  wire hri_pkg::digit_t from_prev,
	input  wire hri_pkg::digit_t from_next,
	output hri_pkg::digit_t      digit
);
	import hri_pkg::*;
	digit_t digit_q;
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			digit_q <= '0;
		end else if (ctl.push) begin
			digit_q <= from_prev;
		end else if (ctl.pop) begin
			digit_q <= from_next;
		end
	end
	assign digit = digit_q;
endmodule
`default_nettype wire

### rtl/hri_row.sv
// ----------------------------------------------------------------------------
// hri_row: chain of digit cells
// Cell 0 is the head: push shifts a digit in there (last digit pushed is the
// most significant), pop shifts the chain toward the head.
// ----------------------------------------------------------------------------
`default_nettype none
module hri_row (
	input  wire logic              clk,
	input  wire hri_pkg::row_ctl_t ctl,
	input  wire hri_pkg::digit_t   digit_in,
	output hri_pkg::digit_t        head
);
	import hri_pkg::*;
	digit_t d [MAX_DIGITS+1];
	assign d[MAX_DIGITS] = '0;
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		hri_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.from_prev((i == 0) ? digit_in : d[(i == 0) ? 0 : i-1]),
			.from_next(d[i+1]),
			.digit    (d[i])
		);
	end
	assign head = d[0];
endmodule
`default_nettype wire

### rtl/halton_radical_inverse_core.sv
// ----------------------------------------------------------------------------
// halton_radical_inverse_core: van der Corput radical inverse, one dimension
// Mirrors the base-radix digits of seq_index about the radix point.
// ----------------------------------------------------------------------------
// One item at a time. The index is split into digits by a restoring
// divider, one quotient bit per cycle; the digits go into a row of cells.
// They are then folded back, most significant first, each by a 32-step
// restoring division acc' = (digit*2^32 + acc) / radix. Each digit is
// split off by the divider steps and a push, and folded by a pop and the
// divider steps; then the result is loaded and the next item accepted.
// Index 0 has no digits and goes straight to the load. Base 2 with 31
// digits is the worst case. The result sits in an output register; the
// next item is accepted while it waits, and a finished result is held in
// the core until that register is free. radix 0 or 1 acts as base 2. The
// user must write configuration only while idle; the core does not
// enforce it.
`default_nettype none
module halton_radical_inverse_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [7:0]             cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [30:0]            seq_index,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [31:0]                 point_fraction
);
	import hri_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_DIGIT, S_FOLD, S_FSTEP} state_t;
	state_t state_q;

	digit_t   radix_q;
	digit_t   base;
	index_t   n_q;        // index being split, then quotient
	index_t   quo_q;
	digit_t   rem_q;      // divider remainder
	logic [RADIX_BITS:0] trial;
	logic [DCNT_BITS-1:0] dcnt_q;
	logic [BCNT_BITS-1:0] bcnt_q;
	frac_t    acc_q;
	frac_t    fq_q;
	row_ctl_t ctl;
	digit_t   head;
	logic     fold_done;

	assign base = (radix_q < 8'd2) ? 8'd2 : radix_q;

	// shared restoring step: trial of remainder with next bit
	logic next_bit;
	always_comb begin
		next_bit = (state_q == S_DIV) ? n_q[INDEX_BITS-1] : acc_q[FRACTION_BITS-1];
		trial    = {rem_q, next_bit};
	end
	logic     take;
	digit_t   rem_nx;
	assign take   = trial >= {1'b0, base};
	assign rem_nx = take ? RADIX_BITS'(trial - {1'b0, base}) : trial[RADIX_BITS-1:0];

	always_comb begin
		ctl      = '0;
		ctl.load = (state_q == S_IDLE) && in_valid;
		ctl.push = (state_q == S_DIGIT);
		ctl.pop  = (state_q == S_FOLD) && (dcnt_q != '0);
	end

	hri_row u_row (.clk(clk), .ctl(ctl), .digit_in(rem_q), .head(head));

	// last fold finished and the output register is free this cycle
	assign fold_done = (state_q == S_FOLD) && (dcnt_q == '0) && (!out_valid || out_ready);

	assign in_ready  = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q   <= 8'd2;
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			dcnt_q    <= '0;
			bcnt_q    <= '0;
		end else begin
			if (cfg_we) radix_q <= cfg_wdata;
			if (fold_done) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						n_q    <= seq_index;
						dcnt_q <= '0;
						acc_q  <= '0;
						state_q <= (seq_index == '0) ? S_FOLD : S_DIV;
						rem_q  <= '0;
						bcnt_q <= '0;
					end
				end
				S_DIV: begin
					rem_q  <= rem_nx;
					quo_q  <= {quo_q[INDEX_BITS-2:0], take};
					n_q    <= {n_q[INDEX_BITS-2:0], 1'b0};
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == BCNT_BITS'(INDEX_BITS - 1)) state_q <= S_DIGIT;
				end
				S_DIGIT: begin
					// remainder is the digit, pushed into the row this cycle
					dcnt_q <= dcnt_q + 1'b1;
					n_q    <= quo_q;
					rem_q  <= '0;
					bcnt_q <= '0;
					state_q <= (quo_q == '0) ? S_FOLD : S_DIV;
				end
				S_FOLD: begin
					if (dcnt_q == '0) begin
						// wait here while an earlier result is still unread
						if (fold_done) begin
							point_fraction <= acc_q;
							state_q        <= S_IDLE;
						end
					end else begin
						rem_q  <= head;
						dcnt_q <= dcnt_q - 1'b1;
						bcnt_q <= '0;
						state_q <= S_FSTEP;
					end
				end
				S_FSTEP: begin
					rem_q  <= rem_nx;
					fq_q   <= {fq_q[FRACTION_BITS-2:0], take};
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == BCNT_BITS'(FRACTION_BITS - 1)) begin
						acc_q   <= {fq_q[FRACTION_BITS-2:0], take};
						state_q <= S_FOLD;
					end else begin
						acc_q   <= {acc_q[FRACTION_BITS-2:0], 1'b0};
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_digits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= DCNT_BITS'(MAX_DIGITS)) else $error("digit count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(point_fraction)))
		else $error("result dropped");
endmodule
`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for halton_radical_inverse_core
// Drives sequence indexes under several radix settings and idle patterns,
// predicts each radical inverse exactly and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import hri_pkg::*;

	// expected fractions, oldest first
	class fraction_board;
		frac_t pending[$];
		int    errors;

		function void note_index(frac_t want);
			pending.push_back(want);
		endfunction

		function void check_fraction(frac_t got);
			frac_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h", $realtime, got);
				errors++;
			end else begin
				want = pending.pop_front();
				if (want !== got) begin
					$display("%0t: point_fraction mismatch, expected %h, actual %h",
						$realtime, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [7:0]    cfg_wdata = '0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [30:0]   seq_index = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [31:0]   point_fraction;

	fraction_board board = new();
	logic [7:0]    cur_radix = 8'd2;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            idle_count = 0;

	halton_radical_inverse_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .seq_index(seq_index),
		.out_valid(out_valid), .out_ready(out_ready), .point_fraction(point_fraction)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exact radical inverse: digits split off least significant first, then
	// folded back most significant first with a long division per digit
	function automatic frac_t radical_inverse(logic [7:0] rdx, logic [30:0] idx);
		logic [63:0] base;
		logic [63:0] n;
		logic [63:0] rem;
		logic [7:0]  digs[$];
		frac_t       acc;
		base = (rdx < 8'd2) ? 64'd2 : {56'd0, rdx};
		n = {33'd0, idx};
		acc = '0;
		while (n != 0) begin
			digs.push_back(8'(n % base));
			n = n / base;
		end
		for (int j = digs.size() - 1; j >= 0; j--) begin
			rem = {56'd0, digs[j]};
			for (int i = FRACTION_BITS - 1; i >= 0; i--) begin
				rem = (rem << 1) | 64'(acc[i]);
				acc[i] = 1'b0;
				if (rem >= base) begin
					rem = rem - base;
					acc[i] = 1'b1;
				end
			end
		end
		return acc;
	endfunction

	// receiver: random stalls, checks at the rising edge
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_fraction(point_fraction);
	end
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// valid stays high after an accept until the next item or an idle cycle
	task automatic send_index(logic [30:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		seq_index <= idx;
		board.note_index(radical_inverse(cur_radix, idx));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic set_radix(logic [7:0] r);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		cur_radix = r;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small indexes keep the digit count low for big radices
	function automatic logic [30:0] rand_index();
		case ($urandom_range(3))
			0: return 31'($urandom);
			1: return 31'($urandom_range(255));
			2: return 31'($urandom_range(65535));
			default: return 31'($urandom) >> $urandom_range(30);
		endcase
	endfunction

	logic [7:0] radix_set[8] = '{8'd2, 8'd255, 8'd3, 8'd0, 8'd1, 8'd7, 8'd128, 8'd254};
	int         idle_mode[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{12, 12}};

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes of index and radix, including radix 0
		foreach (radix_set[k]) begin
			if (k < 4) begin
				set_radix(radix_set[k]);
				send_index(31'd0);
				send_index(31'd1);
				send_index(31'h7fff_ffff);
				send_index(31'h4000_0000);
				send_index(31'h2aaa_aaaa);
				send_index(31'({24'd0, radix_set[k]}));
			end
		end

		// random phases across settings and idle patterns
		for (int ph = 0; ph < 16; ph++) begin
			set_radix(ph % 3 == 0 ? radix_set[ph % 8] : 8'($urandom));
			send_idle_pct = idle_mode[ph % 4][0];
			recv_stall_pct = idle_mode[ph % 4][1];
			for (int i = 0; i < 75; i++) begin
				send_index(rand_index());
				if (i == 37)
					drain();
			end
		end

		drain();
		repeat (100) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
